### hdl/ilid_pkg.sv
// ----------------------------------------------------------------------------
// ilid_pkg: shared types and constants for the indexed list store
// Sizes, action and status codes used by the list store and its checks.
// ----------------------------------------------------------------------------
package ilid_pkg;

    localparam int CAPACITY  = 64;
    localparam int DATA_W    = 32;
    localparam int POS_W     = 7;
    localparam int ACT_W     = 3;
    localparam int STAT_W    = 2;
    localparam int OUT_CNT_W = 7;

    // Count must hold CAPACITY itself; index covers 0 .. CAPACITY-1.
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    // Compare width for positions against the count.
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [ACT_W-1:0] {
        ACT_GET    = 3'd0,
        ACT_FRONT  = 3'd1,
        ACT_BACK   = 3'd2,
        ACT_AT     = 3'd3,
        ACT_DELETE = 3'd4
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

### hdl/indexed_list_insert_delete.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_delete: bounded ordered list with get, insert, delete
// Holds up to CAPACITY signed 32-bit entries; each insert or delete shifts the
// entries at or after its position by one place, all cells in parallel.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                          Direction
//  --------  ---------------------------------------------  ---------
//  request   s_valid s_ready s_action s_position s_data_in   in
//  result    m_valid m_ready m_read_value m_status           out
//            m_entry_count
//
// One item per cycle: an item accepted at one edge has its result in the
// output register after that edge, and the next item may be taken at once.
// The figure is set by the row of entry cells, which all shift in parallel,
// and the one result register.
// Reset clears the entry count and the result valid; entry contents are left
// as they are, since only positions below the count are ever read.
// While a result waits with m_ready low, s_ready drops and the store holds.
//
module indexed_list_insert_delete (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [ilid_pkg::ACT_W-1:0]            s_action,
    input  logic [ilid_pkg::POS_W-1:0]            s_position,
    input  logic signed [ilid_pkg::DATA_W-1:0]    s_data_in,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [ilid_pkg::DATA_W-1:0]    m_read_value,
    output logic [ilid_pkg::STAT_W-1:0]           m_status,
    output logic [ilid_pkg::OUT_CNT_W-1:0]        m_entry_count
);

    localparam int CAPACITY = ilid_pkg::CAPACITY;
    localparam int DATA_W   = ilid_pkg::DATA_W;
    localparam int CNT_W    = ilid_pkg::CNT_W;
    localparam int IDX_W    = ilid_pkg::IDX_W;
    localparam int CMP_W    = ilid_pkg::CMP_W;

    // Entry cells, result register and count.
    logic [DATA_W-1:0]        store_reg [CAPACITY];
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     m_valid_reg;
    logic [DATA_W-1:0]        read_reg;
    logic [DATA_W-1:0]        read_next;
    ilid_pkg::status_t        status_reg;
    ilid_pkg::status_t        status_next;

    logic                     accept;
    logic                     ins_ok;
    logic                     del_ok;
    logic [CMP_W-1:0]         eff_pos;
    logic [CMP_W-1:0]         count_w;
    logic                     full;

    // Take a new item whenever the result register is empty or being drained.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign count_w = CMP_W'(count_reg);
    assign full    = (count_reg == CNT_W'(CAPACITY));

    // Decode the request against the current count.
    always_comb begin
        eff_pos     = CMP_W'(s_position);
        ins_ok      = 1'b0;
        del_ok      = 1'b0;
        read_next   = '0;
        status_next = ilid_pkg::ST_DONE;
        count_next  = count_reg;
        unique case (s_action) inside
            ilid_pkg::ACT_GET: begin
                if (eff_pos < count_w) begin
                    read_next = store_reg[eff_pos[IDX_W-1:0]];
                end else begin
                    read_next   = '1;
                    status_next = ilid_pkg::ST_RANGE;
                end
            end
            ilid_pkg::ACT_FRONT, ilid_pkg::ACT_BACK, ilid_pkg::ACT_AT: begin
                if (s_action == ilid_pkg::ACT_FRONT) begin
                    eff_pos = '0;
                end else if (s_action == ilid_pkg::ACT_BACK) begin
                    eff_pos = count_w;
                end
                // Range check comes before the full check.
                if (eff_pos > count_w) begin
                    status_next = ilid_pkg::ST_RANGE;
                end else if (full) begin
                    status_next = ilid_pkg::ST_FULL;
                end else begin
                    ins_ok     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ilid_pkg::ACT_DELETE: begin
                if (eff_pos < count_w) begin
                    del_ok     = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end else begin
                    status_next = ilid_pkg::ST_RANGE;
                end
            end
            default: begin
                // Unused codes: change nothing, report done.
            end
        endcase
    end

    // Cells above an insert point load from below, at or above a delete point from above.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        localparam logic [CMP_W-1:0] MY_POS = CMP_W'(i);
        logic [DATA_W-1:0] below;
        logic [DATA_W-1:0] above;

        if (i == 0) begin : g_first
            assign below = s_data_in;
        end else begin : g_mid_lo
            assign below = store_reg[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign above = store_reg[i];
        end else begin : g_mid_hi
            assign above = store_reg[i+1];
        end

        always_ff @(posedge aclk) begin
            if (accept) begin
                if (ins_ok && (MY_POS > eff_pos)) begin
                    store_reg[i] <= below;
                end else if (ins_ok && (MY_POS == eff_pos)) begin
                    store_reg[i] <= s_data_in;
                end else if (del_ok && (MY_POS >= eff_pos)) begin
                    store_reg[i] <= above;
                end
            end
        end
    end

    // Control state: count and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load on accept, hold while stalled.
    always_ff @(posedge aclk) begin
        if (accept) begin
            read_reg   <= read_next;
            status_reg <= status_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_read_value  = read_reg;
    assign m_status      = status_reg;
    assign m_entry_count = ilid_pkg::OUT_CNT_W'(count_reg);

    // Count never exceeds the capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // A dropped insert is only reported when the store is full.
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ilid_pkg::ST_FULL)) |-> full)
        else $error("full status with room left");

    // A range error carries -1 on get and 0 otherwise, never store data.
    a_range_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ilid_pkg::ST_RANGE)) |->
        ((m_read_value == '1) || (m_read_value == '0)))
        else $error("range error with unexpected read value");

    // A get leaves the count as it was.
    a_get_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_action == ilid_pkg::ACT_GET)) |=>
        (count_reg == $past(count_reg)))
        else $error("get changed the entry count");

endmodule

### tb/indexed_list_insert_delete_test.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_test: self-checking bench for the list store
// Drives get, insert and delete requests through the valid/ready request
// channel, keeps a shadow copy of the list to work out each result, and
// compares every result item against it field by field. Both channels idle
// in random bursts, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_test;

    localparam int CAPACITY  = ilid_pkg::CAPACITY;
    localparam int DATA_W    = ilid_pkg::DATA_W;
    localparam int POS_W     = ilid_pkg::POS_W;
    localparam int ACT_W     = ilid_pkg::ACT_W;
    localparam int STAT_W    = ilid_pkg::STAT_W;
    localparam int OUT_CNT_W = ilid_pkg::OUT_CNT_W;

    localparam int RANDOM_ITEMS = 1500;
    // Idle-free items at the end of the random part.
    localparam int CALM_ITEMS   = 200;
    // Items per traffic phase; long enough for a growth phase to fill the store.
    localparam int PHASE_ITEMS  = 160;
    // Item index in the random part at which the result side holds off.
    localparam int HOLD_AT      = 300;
    localparam int LONG_HOLD    = 250;
    // Cycles with no handshake on either channel before the run is abandoned.
    localparam int STALL_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 8;

    typedef enum int {
        MIX_GROW,
        MIX_EVEN,
        MIX_SHRINK
    } traffic_mix_t;

    // One expected result item.
    typedef struct {
        logic signed [DATA_W-1:0] value;
        ilid_pkg::status_t        status;
        logic [OUT_CNT_W-1:0]     count;
    } list_result_t;

    // Shadow list plus the queue of results still owed by the block.
    class list_scoreboard;
        logic signed [DATA_W-1:0] entries [CAPACITY];
        int unsigned              fill = 0;
        list_result_t             pending [$];
        int                       errors = 0;

        // Insert value in front of slot pos, or report why it cannot go in.
        function ilid_pkg::status_t place(int unsigned pos,
                                          logic signed [DATA_W-1:0] value);
            if (pos > fill) return ilid_pkg::ST_RANGE;
            if (fill >= CAPACITY) return ilid_pkg::ST_FULL;
            for (int unsigned i = fill; i > pos; i--) entries[i] = entries[i-1];
            entries[pos] = value;
            fill++;
            return ilid_pkg::ST_DONE;
        endfunction

        function void note_request(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                                   logic signed [DATA_W-1:0] value);
            list_result_t res;
            res.value  = '0;
            res.status = ilid_pkg::ST_DONE;
            case (act)
                ilid_pkg::ACT_GET: begin
                    if (pos < fill) begin
                        res.value = entries[pos];
                    end else begin
                        res.value  = -1;
                        res.status = ilid_pkg::ST_RANGE;
                    end
                end
                ilid_pkg::ACT_FRONT:  res.status = place(0, value);
                ilid_pkg::ACT_BACK:   res.status = place(fill, value);
                ilid_pkg::ACT_AT:     res.status = place(pos, value);
                ilid_pkg::ACT_DELETE: begin
                    if (pos < fill) begin
                        for (int unsigned i = pos; i + 1 < fill; i++)
                            entries[i] = entries[i+1];
                        fill--;
                    end else begin
                        res.status = ilid_pkg::ST_RANGE;
                    end
                end
                default: ;
            endcase
            res.count = OUT_CNT_W'(fill);
            pending.push_back(res);
        endfunction

        function void check_result(logic signed [DATA_W-1:0] value,
                                   logic [STAT_W-1:0] status,
                                   logic [OUT_CNT_W-1:0] count);
            list_result_t res;
            if (pending.size() == 0) begin
                $error("result item with no request outstanding");
                errors++;
                return;
            end
            res = pending.pop_front();
            if (value !== res.value) begin
                $error("read_value: expected %0d, got %0d", res.value, value);
                errors++;
            end
            if (status !== res.status) begin
                $error("status: expected %0d, got %0d", res.status, status);
                errors++;
            end
            if (count !== res.count) begin
                $error("entry_count: expected %0d, got %0d", res.count, count);
                errors++;
            end
        endfunction
    endclass

    logic                     aclk          = 1'b0;
    logic                     aresetn       = 1'b0;
    logic                     s_valid       = 1'b0;
    logic                     s_ready;
    logic [ACT_W-1:0]         s_action      = '0;
    logic [POS_W-1:0]         s_position    = '0;
    logic signed [DATA_W-1:0] s_data_in     = '0;
    logic                     m_valid;
    logic                     m_ready       = 1'b0;
    logic signed [DATA_W-1:0] m_read_value;
    logic [STAT_W-1:0]        m_status;
    logic [OUT_CNT_W-1:0]     m_entry_count;

    // Idle switches, cleared for the calm tail; hold_off_req asks for the long hold.
    bit sender_idle_on   = 1'b1;
    bit receiver_idle_on = 1'b1;
    bit hold_off_req     = 1'b0;

    list_scoreboard sb;

    indexed_list_insert_delete i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_position    (s_position),
        .s_data_in     (s_data_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_value  (m_read_value),
        .m_status      (m_status),
        .m_entry_count (m_entry_count)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Offer one request item and hold it until the block takes it. The
    // shadow list is updated here, in line with the handshake, so the next
    // item is always generated against the up-to-date entry count.
    task automatic send_item(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                             logic signed [DATA_W-1:0] value);
        if (sender_idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_action   <= act;
        s_position <= pos;
        s_data_in  <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(act, pos, value);
    endtask

    // Pick one request for the given traffic mix. Most positions land in
    // 0 .. count so gets and deletes hit live entries and inserts land in
    // place; the rest probe one past the end or the whole position range.
    task automatic random_item(traffic_mix_t mix);
        int unsigned              r;
        int unsigned              pr;
        int unsigned              t_get, t_front, t_back, t_at, t_del;
        logic [ACT_W-1:0]         act;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
        case (mix)
            MIX_GROW: begin
                t_get = 15; t_front = 30; t_back = 45; t_at = 70; t_del = 85;
            end
            MIX_SHRINK: begin
                t_get = 20; t_front = 25; t_back = 30; t_at = 40; t_del = 95;
            end
            default: begin
                t_get = 25; t_front = 35; t_back = 45; t_at = 60; t_del = 95;
            end
        endcase
        r = $urandom_range(0, 99);
        if (r < t_get)        act = ilid_pkg::ACT_GET;
        else if (r < t_front) act = ilid_pkg::ACT_FRONT;
        else if (r < t_back)  act = ilid_pkg::ACT_BACK;
        else if (r < t_at)    act = ilid_pkg::ACT_AT;
        else if (r < t_del)   act = ilid_pkg::ACT_DELETE;
        else act = ACT_W'($urandom_range(ilid_pkg::ACT_DELETE + 1, 2**ACT_W - 1));

        pr = $urandom_range(0, 9);
        if (pr < 7)       pos = POS_W'($urandom_range(0, sb.fill));
        else if (pr == 7) pos = POS_W'(sb.fill + 1);
        else              pos = POS_W'($urandom_range(0, 2**POS_W - 1));

        // Mix in the value extremes now and then.
        case ($urandom_range(0, 7))
            0:       value = 32'sh7FFF_FFFF;
            1:       value = 32'sh8000_0000;
            2:       value = -1;
            3:       value = '0;
            default: value = $urandom;
        endcase
        send_item(act, pos, value);
    endtask

    // Result side: ready high by default, random stall bursts, and one long
    // hold-off on request so the result register fills and s_ready drops.
    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (receiver_idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Check every result item as it is taken.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_read_value, m_status, m_entry_count);
        end
    end

    // Abandon the run if neither channel moves an item for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("** indexed_list_insert_delete: FAILED **");
        $finish;
    end

    initial begin : stimulus
        traffic_mix_t mix;
        sb = new;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: empty-store errors first.
        send_item(ilid_pkg::ACT_GET,    7'd0, '0);
        send_item(ilid_pkg::ACT_DELETE, 7'd0, '0);
        send_item(ilid_pkg::ACT_AT,     7'd1, 32'sh1234_5678);
        // Build a short list from every insert flavor, with the value extremes.
        send_item(ilid_pkg::ACT_AT,     7'd0, 32'sh7FFF_FFFF);
        send_item(ilid_pkg::ACT_FRONT,  7'd0, 32'sh8000_0000);
        send_item(ilid_pkg::ACT_BACK,   7'd0, -1);
        send_item(ilid_pkg::ACT_BACK,   7'd0, '0);
        send_item(ilid_pkg::ACT_AT,     7'd2, 32'sh5555_5555);
        // Insert at the count itself appends; one past it is out of range.
        send_item(ilid_pkg::ACT_AT,     7'd5, 32'shAAAA_AAAA);
        send_item(ilid_pkg::ACT_AT,     7'd7, 32'sh0F0F_0F0F);
        send_item(ilid_pkg::ACT_AT,     7'd127, 32'shF0F0_F0F0);
        // Read back every entry, then past the end.
        for (int p = 0; p < 6; p++) send_item(ilid_pkg::ACT_GET, POS_W'(p), '0);
        send_item(ilid_pkg::ACT_GET,    7'd6, '0);
        send_item(ilid_pkg::ACT_GET,    7'd127, '0);
        // Delete head and tail, then out of range.
        send_item(ilid_pkg::ACT_DELETE, 7'd0, '0);
        send_item(ilid_pkg::ACT_DELETE, 7'd4, '0);
        send_item(ilid_pkg::ACT_DELETE, 7'd127, '0);
        // Unused action codes change nothing.
        for (int c = ilid_pkg::ACT_DELETE + 1; c < 2**ACT_W; c++)
            send_item(ACT_W'(c), 7'd127, '1);

        // Random part: cycle grow / even / shrink phases so the store fills
        // to capacity and drains again several times.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            mix = traffic_mix_t'((n / PHASE_ITEMS) % 3);
            if (n == HOLD_AT) hold_off_req = 1'b1;
            if (n == RANDOM_ITEMS - CALM_ITEMS) begin
                sender_idle_on   = 1'b0;
                receiver_idle_on = 1'b0;
            end
            random_item(mix);
        end
        s_valid <= 1'b0;

        // Drain outstanding results, then let the clock run on idle before the verdict.
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("** indexed_list_insert_delete: PASSED **");
        else
            $display("** indexed_list_insert_delete: FAILED **");
        $finish;
    end

endmodule

### sim.f
hdl/ilid_pkg.sv
hdl/indexed_list_insert_delete.sv
tb/indexed_list_insert_delete_test.sv
